@@ rtl/core/tbpf_pkg.sv @@
// ----------------------------------------------------------------------------
// tbpf_pkg
// Shared types and constants of the tile background pixel fetcher.
// ----------------------------------------------------------------------------
package tbpf_pkg;

  localparam int MEM_BYTES  = 8192;
  localparam int ADDR_W     = $clog2(MEM_BYTES);
  localparam int BANK_DEPTH = MEM_BYTES / 2;
  localparam int IDX_W      = $clog2(BANK_DEPTH);

  localparam logic [ADDR_W-1:0] MAP0_BASE = 13'h1800;
  localparam logic [ADDR_W-1:0] MAP1_BASE = 13'h1C00;

  // configuration register indexes
  localparam logic [1:0] CFG_SCROLL_X   = 2'd0;
  localparam logic [1:0] CFG_SCROLL_Y   = 2'd1;
  localparam logic [1:0] CFG_MAP_SELECT = 2'd2;

  // input word kinds
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  typedef struct packed {
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic       map_select;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] index;
  } rd_req_t;

endpackage

@@ rtl/core/tbpf_vram.sv @@
// ----------------------------------------------------------------------------
// tbpf_vram
// Video memory split into an even-byte and an odd-byte bank, one write port
// and one registered read port that returns both bytes of a 16-bit pair.
// ----------------------------------------------------------------------------
module tbpf_vram (
  input  logic              clk,
  input  tbpf_pkg::wr_req_t wr,
  input  tbpf_pkg::rd_req_t rd,
  output logic [7:0]        rdata_even,
  output logic [7:0]        rdata_odd
);

  logic [7:0] even_mem [tbpf_pkg::BANK_DEPTH];
  logic [7:0] odd_mem  [tbpf_pkg::BANK_DEPTH];

  logic [tbpf_pkg::IDX_W-1:0] wr_index;

  assign wr_index = wr.addr[tbpf_pkg::ADDR_W-1:1];

  always_ff @(posedge clk) begin
    if (wr.en && !wr.addr[0]) begin
      even_mem[wr_index] <= wr.data;
    end
    if (wr.en && wr.addr[0]) begin
      odd_mem[wr_index] <= wr.data;
    end
  end

  // read-before-write: a read and a write at the same edge return old data
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata_even <= even_mem[rd.index];
      rdata_odd  <= odd_mem[rd.index];
    end
  end

endmodule

@@ rtl/core/tbpf_fetch.sv @@
// ----------------------------------------------------------------------------
// tbpf_fetch
// Fetch sequencer: issues the map read, then the tile row read on the shared
// memory port, and turns the plane bytes into a color number in the output
// register.
// ----------------------------------------------------------------------------
module tbpf_fetch (
  input  logic                  clk,
  input  logic                  rst,
  input  tbpf_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [tbpf_pkg::ADDR_W-1:0] in_mem_addr,
  input  logic [7:0]            in_mem_data,
  input  logic [7:0]            in_screen_x,
  input  logic [7:0]            in_screen_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_color,
  output tbpf_pkg::wr_req_t     wr,
  output tbpf_pkg::rd_req_t     rd,
  input  logic [7:0]            rdata_even,
  input  logic [7:0]            rdata_odd
);

  logic                        accept;
  logic                        render;
  logic                        tile_issue;
  logic [7:0]                  px;
  logic [7:0]                  py;
  logic [tbpf_pkg::ADDR_W-1:0] map_addr;
  logic [7:0]                  tile;
  logic [tbpf_pkg::IDX_W-1:0]  tile_index;

  // map byte in flight
  logic       p1_valid;
  logic       p1_odd;
  logic [2:0] p1_fy;
  logic [2:0] p1_fx;
  // tile row bytes in flight
  logic       t_valid;
  logic [2:0] t_fx;

  // the read port is busy with the tile row read while a map byte is pending
  assign in_ready = !p1_valid;
  assign accept   = in_valid && in_ready;
  assign render   = accept && (in_mode == tbpf_pkg::MODE_RENDER);

  assign px       = in_screen_x + cfg.scroll_x;
  assign py       = in_screen_y + cfg.scroll_y;
  assign map_addr = (cfg.map_select ? tbpf_pkg::MAP1_BASE : tbpf_pkg::MAP0_BASE)
                  + tbpf_pkg::ADDR_W'({py[7:3], px[7:3]});

  // only start the row read when the output register is sure to have room
  assign tile_issue = p1_valid && !t_valid && (!out_valid || out_ready);

  assign tile       = p1_odd ? rdata_odd : rdata_even;
  assign tile_index = tbpf_pkg::IDX_W'({tile, p1_fy});

  always_comb begin
    wr.en   = accept && (in_mode == tbpf_pkg::MODE_WRITE);
    wr.addr = in_mem_addr;
    wr.data = in_mem_data;
    rd.en   = render || tile_issue;
    rd.index = tile_issue ? tile_index : map_addr[tbpf_pkg::ADDR_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      t_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (render) begin
        p1_valid <= 1'b1;
      end else if (tile_issue) begin
        p1_valid <= 1'b0;
      end
      t_valid <= tile_issue;
      if (t_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (render) begin
      p1_odd <= map_addr[0];
      p1_fy  <= py[2:0];
      p1_fx  <= px[2:0];
    end
    if (tile_issue) begin
      t_fx <= p1_fx;
    end
    // bit 7 is the leftmost pixel, so column fx picks bit 7 - fx
    if (t_valid) begin
      out_color <= {rdata_odd[~t_fx], rdata_even[~t_fx]};
    end
  end

`ifndef NO_ASSERTIONS
  a_room_for_row: assert property (@(posedge clk) disable iff (rst)
    t_valid |-> !out_valid)
    else $error("tile row data arrived while output register full");

  a_map_pending: assert property (@(posedge clk) disable iff (rst)
    render |=> p1_valid && !in_ready)
    else $error("render word did not leave a pending map byte");

  a_row_follows_map: assert property (@(posedge clk) disable iff (rst)
    t_valid |-> $past(p1_valid))
    else $error("tile row data without a preceding map read");

  a_no_port_clash: assert property (@(posedge clk) disable iff (rst)
    !(render && tile_issue))
    else $error("map read and tile row read issued together");
`endif

endmodule

@@ rtl/core/tile_background_pixel_fetch.sv @@
// ----------------------------------------------------------------------------
// tile_background_pixel_fetch
// Background pixel fetcher of a tile-based video unit, 2 bits per pixel.
// ----------------------------------------------------------------------------
// Input stream: s_tuser = 0 writes mem_data to video memory at mem_addr and
// gives no output; s_tuser = 1 renders the pixel at (screen_x, screen_y),
// scrolled by scroll_x/scroll_y modulo 256, and gives one color_id word.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 scroll_x, 1 scroll_y, 2 map_select); write only while the block is idle.
// A render word reads its map byte, then its tile row bytes, into the read
// data registers; the color then goes to the output register (m_tvalid).
// The single memory read port serves the map read, then the dependent tile row
// read; words are taken every cycle unless a tile row read is pending.
// Video memory is not cleared: render only bytes already written.
// Reset clears the pipeline and the registers; memory contents are kept.
// When m_tready is low the result waits in the output register; one more
// render is taken and holds its map byte, then s_tready stays low.
// ----------------------------------------------------------------------------
module tile_background_pixel_fetch (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mem_addr[12:0], mem_data[20:13], screen_x[28:21], screen_y[36:29], zero
  input  logic [39:0] s_tdata,
  // mode[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // color_id[1:0], zero
  output logic [7:0]  m_tdata
);

  tbpf_pkg::cfg_t    cfg;
  tbpf_pkg::wr_req_t wr;
  tbpf_pkg::rd_req_t rd;
  logic [7:0]        rdata_even;
  logic [7:0]        rdata_odd;
  logic [1:0]        color;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tbpf_pkg::CFG_SCROLL_X:   cfg.scroll_x   <= cfg_data;
        tbpf_pkg::CFG_SCROLL_Y:   cfg.scroll_y   <= cfg_data;
        tbpf_pkg::CFG_MAP_SELECT: cfg.map_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tbpf_fetch u_fetch (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_mode     (s_tuser),
    .in_mem_addr (s_tdata[12:0]),
    .in_mem_data (s_tdata[20:13]),
    .in_screen_x (s_tdata[28:21]),
    .in_screen_y (s_tdata[36:29]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_color   (color),
    .wr          (wr),
    .rd          (rd),
    .rdata_even  (rdata_even),
    .rdata_odd   (rdata_odd)
  );

  tbpf_vram u_vram (
    .clk        (clk),
    .wr         (wr),
    .rd         (rd),
    .rdata_even (rdata_even),
    .rdata_odd  (rdata_odd)
  );

  assign m_tdata = {6'b0, color};

endmodule
